// ===== src/gcie_pkg.sv =====
package gcie_pkg;

	localparam int CELLS      = 16;
	localparam int CELL_W     = 4;
	localparam int CNT_W      = CELL_W + 1;
	localparam int DIM_W      = 13;
	localparam int COORD_W    = 12;
	localparam int SUB_W      = 8;
	localparam int IDX_W      = 8;
	localparam int WID_W      = 9;
	localparam int TEXEL_W    = 32;
	localparam int OUT_DATA_W = 72;

	localparam logic [DIM_W-1:0] MIN_DIM   = 13'd16;
	localparam logic [DIM_W-1:0] MAX_DIM   = 13'd4096;
	localparam logic [DIM_W-1:0] RESET_DIM = 13'd256;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// one classified texel, front to back
	typedef struct packed {
		logic               upd;       // white texel inside the grid
		logic [CELL_W-1:0]  cell_col;
		logic [COORD_W-1:0] x;
		logic               band_end;  // last texel of a band: emit and clear
		logic [CELL_W-1:0]  band;
		logic [COORD_W-1:0] bottom;
		logic [DIM_W-1:0]   top_excl;
	} entry_t;

endpackage

// ===== src/glyph_cell_ink_extent_core.sv =====
// Per-cell ink extent of a glyph atlas split into a 16 by 16 grid.
// Input stream: one RGBA texel per word on s_tdata, raster order, top row
// first. One word is taken per cycle; s_tready drops only when the
// four-entry queue between classifier and record keeper is full.
// Output stream: at the last texel of each band of cells, 16 result words
// follow, cell 0 to 15, one per cycle while m_tready is high; m_tlast marks
// the sixteenth. m_tvalid rises once the band's last texel has passed the
// queue, the snapshot and the output register. A band's last texel waits
// while the previous band is still going out, so with m_tready held high
// only 16-texel bands stall the input, once the queue has filled; a
// stalled output fills the queue and then stops the input.
// Configuration: cfg_we writes image_width (index 0) or image_height
// (index 1), saturated to 16..4096; a write restarts the frame. Write only
// while the block is idle.
// Reset: 256 by 256 image, counters at the top-left texel, records empty,
// no output pending.
module glyph_cell_ink_extent_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [gcie_pkg::DIM_W-1:0]           cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [gcie_pkg::TEXEL_W-1:0]         s_tdata,   // texel_rgba
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// glyph_index, has_ink, ink_left_col, ink_right_col_excl, ink_width,
	// cell_bottom_row, cell_top_row_excl, zero pad
	output logic [gcie_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast    // last_of_band
);

	logic             push, q_full, head_valid, pop;
	gcie_pkg::entry_t push_entry, head_entry;

	gcie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_texel   (s_tdata),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	gcie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.flush      (cfg_we),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	gcie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

// ===== src/gcie_front.sv =====
module gcie_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [gcie_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gcie_pkg::TEXEL_W-1:0]   in_texel,
	output logic                           push,
	output gcie_pkg::entry_t               push_entry,
	input  logic                           q_full
);

	logic [gcie_pkg::DIM_W-1:0]   w_q, h_q;
	logic [gcie_pkg::DIM_W-1:0]   top_excl_q;
	logic [gcie_pkg::COORD_W-1:0] col_q, row_q;
	logic [gcie_pkg::SUB_W-1:0]   sub_col_q, sub_row_q;
	logic [gcie_pkg::CNT_W-1:0]   cell_q, band_q;

	logic [gcie_pkg::DIM_W-1:0]   cfg_clamped;
	logic [gcie_pkg::WID_W-1:0]   cw, ch;
	logic                         accept, in_rows, in_grid, white;
	logic                         line_end, frame_end, cell_end, band_row_end;

	always_comb begin
		priority if (cfg_data < gcie_pkg::MIN_DIM) begin
			cfg_clamped = gcie_pkg::MIN_DIM;
		end else if (cfg_data > gcie_pkg::MAX_DIM) begin
			cfg_clamped = gcie_pkg::MAX_DIM;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	assign cw = w_q[gcie_pkg::DIM_W-1:gcie_pkg::CELL_W];
	assign ch = h_q[gcie_pkg::DIM_W-1:gcie_pkg::CELL_W];

	assign in_ready     = !q_full;
	assign accept       = in_valid && in_ready;
	assign white        = &in_texel;
	assign in_rows      = !band_q[gcie_pkg::CELL_W];
	assign in_grid      = in_rows && !cell_q[gcie_pkg::CELL_W];
	assign line_end     = {1'b0, col_q} == w_q - 13'd1;
	assign frame_end    = {1'b0, row_q} == h_q - 13'd1;
	assign cell_end     = {1'b0, sub_col_q} == cw - 9'd1;
	assign band_row_end = {1'b0, sub_row_q} == ch - 9'd1;

	assign push                = accept;
	assign push_entry.upd      = white && in_grid;
	assign push_entry.cell_col = cell_q[gcie_pkg::CELL_W-1:0];
	assign push_entry.x        = col_q;
	assign push_entry.band_end = in_rows && line_end && band_row_end;
	assign push_entry.band     = band_q[gcie_pkg::CELL_W-1:0];
	assign push_entry.top_excl = top_excl_q;
	assign push_entry.bottom   = gcie_pkg::COORD_W'(top_excl_q - {4'd0, ch});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= gcie_pkg::RESET_DIM;
			h_q        <= gcie_pkg::RESET_DIM;
			top_excl_q <= gcie_pkg::RESET_DIM;
			col_q      <= '0;
			row_q      <= '0;
			sub_col_q  <= '0;
			sub_row_q  <= '0;
			cell_q     <= '0;
			band_q     <= '0;
		end else if (cfg_we) begin
			// any write restarts the frame
			col_q     <= '0;
			row_q     <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
			cell_q    <= '0;
			band_q    <= '0;
			unique case (cfg_index)
				gcie_pkg::REG_IMAGE_WIDTH: begin
					w_q        <= cfg_clamped;
					top_excl_q <= h_q;
				end
				gcie_pkg::REG_IMAGE_HEIGHT: begin
					h_q        <= cfg_clamped;
					top_excl_q <= cfg_clamped;
				end
				default: begin
					top_excl_q <= h_q;
				end
			endcase
		end else if (accept) begin
			if (line_end) begin
				col_q     <= '0;
				sub_col_q <= '0;
				cell_q    <= '0;
				if (frame_end) begin
					row_q      <= '0;
					sub_row_q  <= '0;
					band_q     <= '0;
					top_excl_q <= h_q;
				end else begin
					row_q <= row_q + 12'd1;
					if (band_row_end) begin
						sub_row_q <= '0;
						if (in_rows) begin
							band_q     <= band_q + 5'd1;
							top_excl_q <= top_excl_q - {4'd0, ch};
						end
					end else begin
						sub_row_q <= sub_row_q + 8'd1;
					end
				end
			end else begin
				col_q <= col_q + 12'd1;
				if (cell_end) begin
					sub_col_q <= '0;
					if (!cell_q[gcie_pkg::CELL_W]) begin
						cell_q <= cell_q + 5'd1;
					end
				end else begin
					sub_col_q <= sub_col_q + 8'd1;
				end
			end
		end
	end

endmodule

// ===== src/gcie_queue.sv =====
module gcie_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             flush,
	input  logic             push,
	input  gcie_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output gcie_pkg::entry_t head_entry
);

	gcie_pkg::entry_t             slot_q [gcie_pkg::QDEPTH];
	logic [gcie_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [gcie_pkg::QCNT_W-1:0]  count_q;
	logic                         do_push, do_pop;

	assign full       = count_q == gcie_pkg::QCNT_W'(gcie_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/gcie_back.sv =====
module gcie_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic                              head_valid,
	input  gcie_pkg::entry_t                  head_entry,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gcie_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_last
);

	localparam int N = gcie_pkg::CELLS;
	localparam int CW = gcie_pkg::COORD_W;

	// running records of the current band
	logic [CW-1:0] left_q  [N];
	logic [CW-1:0] right_q [N];
	logic [N-1:0]  seen_q;

	// records of the finished band being sent out
	logic [CW-1:0] snap_left_q  [N];
	logic [CW-1:0] snap_right_q [N];
	logic [N-1:0]  snap_seen_q;
	logic [gcie_pkg::CELL_W-1:0]  snap_band_q;
	logic [CW-1:0]                snap_bottom_q;
	logic [gcie_pkg::DIM_W-1:0]   snap_top_q;

	logic                         emit_busy_q;
	logic [gcie_pkg::CELL_W-1:0]  emit_idx_q;
	logic                         out_valid_q;
	logic [gcie_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                         out_last_q;

	logic [CW-1:0] new_left, new_right;
	logic          upd_hit_left, upd_hit_right;
	logic          load_out;

	logic                         o_ink;
	logic [CW-1:0]                o_left;
	logic [gcie_pkg::DIM_W-1:0]   o_rex;
	logic [gcie_pkg::WID_W-1:0]   o_wid;
	logic [gcie_pkg::IDX_W-1:0]   o_idx;
	logic [gcie_pkg::DIM_W-1:0]   rex_full;

	// a band end waits while the previous band is still going out
	assign pop = head_valid && !(head_entry.band_end && emit_busy_q);

	assign upd_hit_left  = !seen_q[head_entry.cell_col] ||
		head_entry.x < left_q[head_entry.cell_col];
	assign upd_hit_right = !seen_q[head_entry.cell_col] ||
		head_entry.x > right_q[head_entry.cell_col];
	assign new_left  = upd_hit_left  ? head_entry.x : left_q[head_entry.cell_col];
	assign new_right = upd_hit_right ? head_entry.x : right_q[head_entry.cell_col];

	assign load_out = emit_busy_q && (!out_valid_q || out_ready);

	assign o_ink    = snap_seen_q[emit_idx_q];
	assign rex_full = {1'b0, snap_right_q[emit_idx_q]} + 13'd1;
	assign o_left   = o_ink ? snap_left_q[emit_idx_q] : '0;
	assign o_rex    = o_ink ? rex_full : '0;
	assign o_wid    = gcie_pkg::WID_W'(o_rex - {1'b0, o_left});
	assign o_idx    = {snap_band_q, emit_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				left_q[i]  <= '1;
				right_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (restart) begin
			for (int i = 0; i < N; i++) begin
				left_q[i]  <= '1;
				right_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (pop) begin
			if (head_entry.band_end) begin
				for (int i = 0; i < N; i++) begin
					left_q[i]  <= '1;
					right_q[i] <= '0;
				end
				seen_q <= '0;
			end else if (head_entry.upd) begin
				left_q[head_entry.cell_col]  <= new_left;
				right_q[head_entry.cell_col] <= new_right;
				seen_q[head_entry.cell_col]  <= 1'b1;
			end
		end
	end

	// snapshot takes the records with this word's update merged in
	always_ff @(posedge clk) begin
		if (pop && head_entry.band_end) begin
			for (int i = 0; i < N; i++) begin
				if (head_entry.upd && head_entry.cell_col == gcie_pkg::CELL_W'(i)) begin
					snap_left_q[i]  <= new_left;
					snap_right_q[i] <= new_right;
					snap_seen_q[i]  <= 1'b1;
				end else begin
					snap_left_q[i]  <= left_q[i];
					snap_right_q[i] <= right_q[i];
					snap_seen_q[i]  <= seen_q[i];
				end
			end
			snap_band_q   <= head_entry.band;
			snap_bottom_q <= head_entry.bottom;
			snap_top_q    <= head_entry.top_excl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_busy_q <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (restart) begin
			emit_busy_q <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head_entry.band_end) begin
				emit_busy_q <= 1'b1;
				emit_idx_q  <= '0;
			end else if (load_out) begin
				emit_idx_q <= emit_idx_q + 1'b1;
				if (&emit_idx_q) begin
					emit_busy_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {4'd0, snap_top_q, snap_bottom_q, o_wid, o_rex, o_left, o_ink, o_idx};
			out_last_q <= &emit_idx_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule
